// ===== design/apsc_pkg.sv =====
// ----------------------------------------------------------------------------
// apsc_pkg: shared types and constants of the accessory power controller
// Register indexes, reset values, and the beat layouts of both channels.
// ----------------------------------------------------------------------------
package apsc_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_VOLT_THRESHOLD     = 3'd0,
    REG_SHUTDOWN_TIMEOUT   = 3'd1,
    REG_IGNITION_THRESHOLD = 3'd2,
    REG_UNDERVOLT_LIMIT    = 3'd3,
    REG_REENABLE_DELAY     = 3'd4
  } cfg_reg_e;

  localparam logic [9:0]  VOLT_THRESHOLD_RST     = 10'd110;
  localparam logic [15:0] SHUTDOWN_TIMEOUT_RST   = 16'd6300;
  localparam logic [9:0]  IGNITION_THRESHOLD_RST = 10'd70;
  localparam logic [7:0]  UNDERVOLT_LIMIT_RST    = 8'd240;
  localparam logic [15:0] REENABLE_DELAY_RST     = 16'd30;

  localparam logic [15:0] FORCED_SHUTDOWN_LOAD = 16'd63000;
  localparam logic [10:0] UNDERVOLT_MARGIN     = 11'd2;
  localparam logic [7:0]  UNDERVOLT_MAX        = 8'd255;

  typedef struct packed {
    logic [9:0]  volt_threshold;
    logic [15:0] shutdown_timeout;
    logic [9:0]  ignition_threshold;
    logic [7:0]  undervolt_limit;
    logic [15:0] reenable_delay;
  } cfg_t;

  typedef struct packed {
    logic [9:0] ignition_level;
    logic [9:0] supply_level;
    logic [9:0] switch_positions;
    logic [3:0] trip_flags;
    logic       second_tick;
  } reading_t;

  typedef struct packed {
    logic [6:0]  accessory_enables;
    logic [2:0]  main_relays;
    logic        low_current_relay;
    logic        led_on;
    logic        power_off;
    logic [3:0]  tripped_mask;
    logic [15:0] shutdown_count;
    logic [7:0]  undervolt_count;
  } report_t;

endpackage

// ===== design/apsc_if.sv =====
// ----------------------------------------------------------------------------
// apsc_if: valid/ready channels of the accessory power controller
// One interface for the reading beats, one for the report beats.
// ----------------------------------------------------------------------------
interface apsc_reading_if;
  logic       valid;
  logic       ready;
  logic [9:0] ignition_level;
  logic [9:0] supply_level;
  logic [9:0] switch_positions;
  logic [3:0] trip_flags;
  logic       second_tick;

  modport source (output valid, ignition_level, supply_level, switch_positions,
                  trip_flags, second_tick, input ready);
  modport sink   (input valid, ignition_level, supply_level, switch_positions,
                  trip_flags, second_tick, output ready);
endinterface

interface apsc_report_if;
  logic        valid;
  logic        ready;
  logic [6:0]  accessory_enables;
  logic [2:0]  main_relays;
  logic        low_current_relay;
  logic        led_on;
  logic        power_off;
  logic [3:0]  tripped_mask;
  logic [15:0] shutdown_count;
  logic [7:0]  undervolt_count;

  modport source (output valid, accessory_enables, main_relays, low_current_relay,
                  led_on, power_off, tripped_mask, shutdown_count, undervolt_count,
                  input ready);
  modport sink   (input valid, accessory_enables, main_relays, low_current_relay,
                  led_on, power_off, tripped_mask, shutdown_count, undervolt_count,
                  output ready);
endinterface

// ===== design/accessory_power_shutdown_controller.sv =====
// ----------------------------------------------------------------------------
// accessory_power_shutdown_controller: accessory and relay power sequencing
// Top level: input register, control pass, report register, config port.
// ----------------------------------------------------------------------------
// Each reading beat is one control pass and yields exactly one report beat.
// A reading is captured in an input register; once the report register has
// room, the control pass evaluates it against the held controller state,
// commits the new state and loads the report register, which holds the
// report beat until it is taken.
// One reading can be accepted every cycle while the report sink keeps up: the
// pass is a single level of compares and counter updates, and the input
// stage keeps accepting while the report register is empty or being drained.
// When the report sink stalls, the input register fills and then ready drops.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// should only change while no reading is in flight.
module accessory_power_shutdown_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [apsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [apsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  apsc_reading_if.sink                     reading,
  apsc_report_if.source                    report
);

  apsc_pkg::cfg_t     cfg;
  apsc_pkg::reading_t rd_in;
  apsc_pkg::reading_t rd_held;
  apsc_pkg::report_t  rpt_pass;
  apsc_pkg::report_t  rpt_held;
  logic               rd_valid;
  logic               rpt_valid;
  logic               step;

  apsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign rd_in.ignition_level   = reading.ignition_level;
  assign rd_in.supply_level     = reading.supply_level;
  assign rd_in.switch_positions = reading.switch_positions;
  assign rd_in.trip_flags       = reading.trip_flags;
  assign rd_in.second_tick      = reading.second_tick;

  // A held reading is processed when the report register has room.
  assign step          = rd_valid && (!rpt_valid || report.ready);
  assign reading.ready = !rd_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (reading.ready) begin
      rd_valid <= reading.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (reading.valid && reading.ready) begin
      rd_held <= rd_in;
    end
  end

  apsc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cfg  (cfg),
    .rd   (rd_held),
    .rpt  (rpt_pass)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (step) begin
      rpt_valid <= 1'b1;
    end else if (report.ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rpt_held <= rpt_pass;
    end
  end

  assign report.valid             = rpt_valid;
  assign report.accessory_enables = rpt_held.accessory_enables;
  assign report.main_relays       = rpt_held.main_relays;
  assign report.low_current_relay = rpt_held.low_current_relay;
  assign report.led_on            = rpt_held.led_on;
  assign report.power_off         = rpt_held.power_off;
  assign report.tripped_mask      = rpt_held.tripped_mask;
  assign report.shutdown_count    = rpt_held.shutdown_count;
  assign report.undervolt_count   = rpt_held.undervolt_count;

  // An accepted reading always occupies the input register next cycle.
  a_rd_capture: assert property (@(posedge clk) disable iff (rst)
    reading.valid && reading.ready |=> rd_valid)
    else $error("accepted reading not held");

  // A processed pass always presents a report next cycle.
  a_rpt_load: assert property (@(posedge clk) disable iff (rst)
    step |=> rpt_valid)
    else $error("processed pass produced no report");

  // A power-off pulse comes with a cleared shutdown counter.
  a_pwr_off_clears: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && rpt_held.power_off |-> rpt_held.shutdown_count == 16'd0)
    else $error("power off with nonzero shutdown count");

endmodule

// ===== design/apsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// apsc_cfg_regs: configuration registers
// Write-only register file; each register loads the low bits of the data that fit its width.
// ----------------------------------------------------------------------------
module apsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [apsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [apsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output apsc_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.volt_threshold     <= apsc_pkg::VOLT_THRESHOLD_RST;
      cfg.shutdown_timeout   <= apsc_pkg::SHUTDOWN_TIMEOUT_RST;
      cfg.ignition_threshold <= apsc_pkg::IGNITION_THRESHOLD_RST;
      cfg.undervolt_limit    <= apsc_pkg::UNDERVOLT_LIMIT_RST;
      cfg.reenable_delay     <= apsc_pkg::REENABLE_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        apsc_pkg::REG_VOLT_THRESHOLD:     cfg.volt_threshold     <= cfg_data[9:0];
        apsc_pkg::REG_SHUTDOWN_TIMEOUT:   cfg.shutdown_timeout   <= cfg_data;
        apsc_pkg::REG_IGNITION_THRESHOLD: cfg.ignition_threshold <= cfg_data[9:0];
        apsc_pkg::REG_UNDERVOLT_LIMIT:    cfg.undervolt_limit    <= cfg_data[7:0];
        apsc_pkg::REG_REENABLE_DELAY:     cfg.reenable_delay     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/apsc_core.sv =====
// ----------------------------------------------------------------------------
// apsc_core: control pass logic and controller state
// Computes one control pass from the held state and a reading, and commits
// the new state when the pass is taken.
// ----------------------------------------------------------------------------
module apsc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  apsc_pkg::cfg_t     cfg,
  input  apsc_pkg::reading_t rd,
  output apsc_pkg::report_t  rpt
);

  logic [6:0]  accessory_state, accessory_state_next;
  logic [2:0]  relay_state, relay_state_next;
  logic        low_current_state, low_current_state_next;
  logic        led_state, led_state_next;
  logic        ignition_seen, ignition_seen_next;
  logic [7:0]  undervolt_counter, undervolt_counter_next;
  logic [15:0] shutdown_counter, shutdown_counter_next;
  logic [15:0] reenable_counter, reenable_counter_next;
  logic [3:0]  trip_latch, trip_latch_next;
  logic        power_off;

  function automatic logic [7:0] uv_inc(input logic [7:0] c);
    return (c == apsc_pkg::UNDERVOLT_MAX) ? c : c + 8'd1;
  endfunction

  always_comb begin
    accessory_state_next   = accessory_state & ~{rd.trip_flags, 3'b000};
    trip_latch_next        = trip_latch | rd.trip_flags;
    relay_state_next       = relay_state;
    low_current_state_next = low_current_state;
    led_state_next         = led_state;
    ignition_seen_next     = ignition_seen;
    undervolt_counter_next = undervolt_counter;
    shutdown_counter_next  = shutdown_counter;
    reenable_counter_next  = reenable_counter;
    power_off              = 1'b0;

    if (rd.ignition_level < cfg.ignition_threshold) begin
      ignition_seen_next   = 1'b0;
      accessory_state_next = accessory_state_next & rd.switch_positions[9:3];
      relay_state_next     = relay_state & rd.switch_positions[2:0];

      // Deep undervolt counts twice per pass.
      if ({1'b0, rd.supply_level} + apsc_pkg::UNDERVOLT_MARGIN
          < {1'b0, cfg.volt_threshold}) begin
        undervolt_counter_next = uv_inc(undervolt_counter_next);
      end
      if (rd.supply_level < cfg.volt_threshold) begin
        led_state_next         = ~led_state_next;
        undervolt_counter_next = uv_inc(undervolt_counter_next);
        if (undervolt_counter_next > cfg.undervolt_limit) begin
          shutdown_counter_next = apsc_pkg::FORCED_SHUTDOWN_LOAD;
        end
      end else begin
        undervolt_counter_next = '0;
      end

      if (rd.second_tick) begin
        led_state_next        = ~led_state_next;
        shutdown_counter_next = shutdown_counter_next + 16'd1;
        reenable_counter_next = reenable_counter + 16'd1;
        if (shutdown_counter_next > cfg.shutdown_timeout) begin
          shutdown_counter_next = '0;
          power_off             = 1'b1;
        end
      end
    end else begin
      if (reenable_counter > cfg.reenable_delay) begin
        reenable_counter_next = '0;
        accessory_state_next  = '1;
        trip_latch_next       = '0;
      end
      if (!ignition_seen) begin
        accessory_state_next = '1;
        ignition_seen_next   = 1'b1;
      end
      relay_state_next       = '1;
      low_current_state_next = 1'b1;
      undervolt_counter_next = '0;
      shutdown_counter_next  = '0;
      if (rd.second_tick) begin
        reenable_counter_next = reenable_counter_next + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accessory_state   <= '0;
      relay_state       <= '0;
      low_current_state <= 1'b0;
      led_state         <= 1'b1;
      ignition_seen     <= 1'b0;
      undervolt_counter <= '0;
      shutdown_counter  <= '0;
      reenable_counter  <= '0;
      trip_latch        <= '0;
    end else if (step) begin
      accessory_state   <= accessory_state_next;
      relay_state       <= relay_state_next;
      low_current_state <= low_current_state_next;
      led_state         <= led_state_next;
      ignition_seen     <= ignition_seen_next;
      undervolt_counter <= undervolt_counter_next;
      shutdown_counter  <= shutdown_counter_next;
      reenable_counter  <= reenable_counter_next;
      trip_latch        <= trip_latch_next;
    end
  end

  assign rpt.accessory_enables = accessory_state_next;
  assign rpt.main_relays       = relay_state_next;
  assign rpt.low_current_relay = low_current_state_next;
  assign rpt.led_on            = led_state_next;
  assign rpt.power_off         = power_off;
  assign rpt.tripped_mask      = trip_latch_next;
  assign rpt.shutdown_count    = shutdown_counter_next;
  assign rpt.undervolt_count   = undervolt_counter_next;

endmodule
